[src/decs_pkg.sv]
package decs_pkg;

  localparam int CHECK_BITS = 8;
  localparam int CODE_BITS  = 16;
  localparam int DATA_BITS  = 8;
  localparam int POS_W      = 5;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = $clog2(CODE_BITS);
  localparam int REG_IDX_W  = $clog2(CHECK_BITS);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [CODE_BITS-1:0] DATA_MASK =
    CODE_BITS'(((64'd1 << DATA_BITS) - 64'd1) << (CODE_BITS - DATA_BITS));
  localparam logic [CODE_BITS-1:0] TOP_BIT = {1'b1, {(CODE_BITS-1){1'b0}}};
  localparam logic [IDX_W-1:0] LAST_A = IDX_W'(CODE_BITS - 2);

  typedef logic [0:CHECK_BITS-1][CODE_BITS-1:0] rows_t;

  localparam rows_t ROW_RESET = '{
    16'd18304, 16'd16704, 16'd38176, 16'd15632,
    16'd53000, 16'd12548, 16'd55554, 16'd8961
  };

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE   = 2'd0,
    ST_SINGLE = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_FAIL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SINGLE,
    BK_PAIR
  } back_state_e;

  typedef struct packed {
    logic                  direct;
    logic [CODE_BITS-1:0]  word;
    logic [CHECK_BITS-1:0] syn;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  word;
    logic [CHECK_BITS-1:0] syn;
    status_e               status;
    logic [POS_W-1:0]      pos_a;
    logic [POS_W-1:0]      pos_b;
  } res_t;

endpackage

[src/decs_if.sv]
interface decs_req_if import decs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [CODE_BITS-1:0] word_in;

  modport source (output valid, op, word_in, input ready);
  modport sink (input valid, op, word_in, output ready);
endinterface

interface decs_rsp_if import decs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CODE_BITS-1:0]  word_out;
  logic [CHECK_BITS-1:0] syndrome;
  logic [STATUS_W-1:0]   status;
  logic [POS_W-1:0]      error_pos_a;
  logic [POS_W-1:0]      error_pos_b;

  modport source (output valid, word_out, syndrome, status, error_pos_a, error_pos_b,
                  input ready);
  modport sink (input valid, word_out, syndrome, status, error_pos_a, error_pos_b,
                output ready);
endinterface

[src/double_error_syndrome_codec.sv]
// Channel   Direction  Handshake      Payload
// req_i     in         valid/ready    op, word_in
// rsp_o     out        valid/ready    word_out, syndrome, status, error_pos_a, error_pos_b
// APB       in/out     psel/penable   check_row_0 .. check_row_7 at byte address 4*i
//
// Encodes and decodes with a zero syndrome go from the pop straight into the output register.
// A nonzero syndrome goes first to the single-column compare, then to the pair search,
// which tries the first column of the pair in order from 0 to CODE_BITS - 2; a found
// result waits there while the output slot is busy. The front keeps taking requests
// into the two-entry queue until it is full. Reset restores the default check rows.
// A stalled response holds in the output register and stops the back end only.
module double_error_syndrome_codec import decs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  decs_req_if.sink              req_i,
  decs_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  rows_t          rows_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic           push, pop;
  job_t           push_job, head_job;
  q_status_t      q_status;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (int'(reg_idx) < CHECK_BITS) ? APB_DATA_W'(rows_q[reg_idx]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROW_RESET;
    end else if (psel && penable && pwrite && int'(reg_idx) < CHECK_BITS) begin
      rows_q[reg_idx] <= pwdata[CODE_BITS-1:0];
    end
  end

  decs_front u_front (
    .req_i      (req_i),
    .rows_i     (rows_q),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  decs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .status_o (q_status),
    .job_o    (head_job)
  );

  decs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rows_i     (rows_q),
    .q_status_i (q_status),
    .job_i      (head_job),
    .pop_o      (pop),
    .rsp_o      (rsp_o)
  );

endmodule

[src/decs_front.sv]
module decs_front import decs_pkg::*; (
  decs_req_if.sink  req_i,
  input  rows_t     rows_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output job_t      job_o
);

  logic [CHECK_BITS-1:0] par;
  logic [CHECK_BITS-1:0] syn;
  logic [CODE_BITS-1:0]  enc_word;

  always_comb begin
    enc_word = req_i.word_in & DATA_MASK;
    for (int r = 0; r < CHECK_BITS; r++) begin
      par[CHECK_BITS-1-r] = ^(rows_i[r] & req_i.word_in & DATA_MASK);
      syn[CHECK_BITS-1-r] = ^(rows_i[r] & req_i.word_in);
    end
    for (int r = 0; r < CHECK_BITS; r++) begin
      if (CODE_BITS - 1 - DATA_BITS - r >= 0) begin
        enc_word[CODE_BITS-1-DATA_BITS-r] = par[CHECK_BITS-1-r];
      end
    end
  end

  always_comb begin
    req_i.ready = !q_status_i.full;
    push_o      = req_i.valid && !q_status_i.full;
    if (op_e'(req_i.op) == OP_ENCODE) begin
      job_o.direct = 1'b1;
      job_o.word   = enc_word;
      job_o.syn    = '0;
    end else begin
      job_o.direct = (syn == '0);
      job_o.word   = req_i.word_in;
      job_o.syn    = syn;
    end
  end

endmodule

[src/decs_queue.sv]
module decs_queue import decs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output q_status_t status_o,
  output job_t      job_o
);

  job_t              mem_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
    status_o.full  = (count_q == QCNT_W'(Q_DEPTH));
    status_o.empty = (count_q == '0);
    job_o          = mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

[src/decs_back.sv]
module decs_back import decs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rows_t     rows_i,
  input  q_status_t q_status_i,
  input  job_t      job_i,
  output logic      pop_o,
  decs_rsp_if.source rsp_o
);

  back_state_e state_q, state_d;
  job_t        cur_q, cur_d;
  logic [IDX_W-1:0] a_q, a_d;
  res_t        res_q, res_d;
  logic        out_valid_q, out_valid_d;

  logic [0:CODE_BITS-1][CHECK_BITS-1:0] cols;
  logic             hit_s, hit_p, slot_free;
  logic [IDX_W-1:0] idx_s, idx_p;

  always_comb begin
    for (int c = 0; c < CODE_BITS; c++) begin
      for (int r = 0; r < CHECK_BITS; r++) begin
        cols[c][CHECK_BITS-1-r] = rows_i[r][CODE_BITS-1-c];
      end
    end
  end

  always_comb begin
    hit_s = 1'b0;
    idx_s = '0;
    hit_p = 1'b0;
    idx_p = '0;
    for (int c = CODE_BITS - 1; c >= 0; c--) begin
      if (cols[c] == cur_q.syn) begin
        hit_s = 1'b1;
        idx_s = IDX_W'(c);
      end
      if ((IDX_W'(c) > a_q) && ((cols[a_q] ^ cols[c]) == cur_q.syn)) begin
        hit_p = 1'b1;
        idx_p = IDX_W'(c);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    a_d         = a_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    slot_free   = !out_valid_q || rsp_o.ready;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty && slot_free) begin
          pop_o = 1'b1;
          if (job_i.direct) begin
            res_d.word   = job_i.word;
            res_d.syn    = job_i.syn;
            res_d.status = ST_NONE;
            res_d.pos_a  = '0;
            res_d.pos_b  = '0;
            out_valid_d  = 1'b1;
          end else begin
            cur_d   = job_i;
            state_d = BK_SINGLE;
          end
        end
      end
      BK_SINGLE: begin
        if (hit_s) begin
          if (slot_free) begin
            res_d.word   = cur_q.word ^ (TOP_BIT >> idx_s);
            res_d.syn    = cur_q.syn;
            res_d.status = ST_SINGLE;
            res_d.pos_a  = POS_W'(idx_s) + 1'b1;
            res_d.pos_b  = '0;
            out_valid_d  = 1'b1;
            state_d      = BK_IDLE;
          end
        end else begin
          a_d     = '0;
          state_d = BK_PAIR;
        end
      end
      BK_PAIR: begin
        if (hit_p || a_q == LAST_A) begin
          if (slot_free) begin
            res_d.syn   = cur_q.syn;
            out_valid_d = 1'b1;
            state_d     = BK_IDLE;
            if (hit_p) begin
              res_d.word   = cur_q.word ^ (TOP_BIT >> a_q) ^ (TOP_BIT >> idx_p);
              res_d.status = ST_DOUBLE;
              res_d.pos_a  = POS_W'(a_q) + 1'b1;
              res_d.pos_b  = POS_W'(idx_p) + 1'b1;
            end else begin
              res_d.word   = cur_q.word;
              res_d.status = ST_FAIL;
              res_d.pos_a  = '0;
              res_d.pos_b  = '0;
            end
          end
        end else begin
          a_d = a_q + 1'b1;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    a_q   <= a_d;
    res_q <= res_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.word_out    = res_q.word;
  assign rsp_o.syndrome    = res_q.syn;
  assign rsp_o.status      = res_q.status;
  assign rsp_o.error_pos_a = res_q.pos_a;
  assign rsp_o.error_pos_b = res_q.pos_b;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == BK_IDLE)
    else $error("queue popped while a search is running");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PAIR |-> a_q <= LAST_A)
    else $error("pair search ran past the last first column");

  a_double_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_DOUBLE |-> res_q.pos_a < res_q.pos_b
      && res_q.pos_a != '0)
    else $error("double correction with misordered columns");

  a_clean_syn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_NONE |-> res_q.syn == '0)
    else $error("no-error result with a nonzero syndrome");

  a_fail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_FAIL |-> res_q.pos_a == '0 && res_q.pos_b == '0
      && res_q.syn != '0)
    else $error("uncorrectable result with positions set");

endmodule

[tb/tb_double_error_syndrome_codec.sv]
module tb_double_error_syndrome_codec;
  import decs_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 40;

  localparam logic [CODE_BITS-1:0] DEFAULT_ROWS [CHECK_BITS] = '{
    16'd18304, 16'd16704, 16'd38176, 16'd15632,
    16'd53000, 16'd12548, 16'd55554, 16'd8961
  };

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_CLEAN,
    ROW_SEEK
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    op_e                  op;
    logic [CODE_BITS-1:0] word;
    logic [CODE_BITS-1:0] aux;
  } codec_vector_t;

  // A clean row expects aux as the output word with every other field zero.
  // A seek row steps the word upward until the decode status equals aux.
  localparam codec_vector_t DIRECTED [18] = '{
    '{ROW_CLEAN,   OP_ENCODE, 16'h0000, 16'h0000},
    '{ROW_CLEAN,   OP_ENCODE, 16'h00FF, 16'h0000},
    '{ROW_CLEAN,   OP_DECODE, 16'h0000, 16'h0000},
    '{ROW_PREDICT, OP_ENCODE, 16'hFF00, 16'h0000},
    '{ROW_PREDICT, OP_ENCODE, 16'hFFFF, 16'h0000},
    '{ROW_PREDICT, OP_ENCODE, 16'h8000, 16'h0000},
    '{ROW_PREDICT, OP_ENCODE, 16'h0100, 16'h0000},
    '{ROW_PREDICT, OP_ENCODE, 16'h5AA5, 16'h0000},
    '{ROW_PREDICT, OP_DECODE, 16'hFFFF, 16'h0000},
    '{ROW_PREDICT, OP_DECODE, 16'h8000, 16'h0000},
    '{ROW_PREDICT, OP_DECODE, 16'h0001, 16'h0000},
    '{ROW_PREDICT, OP_DECODE, 16'hA5C3, 16'h0000},
    '{ROW_SEEK,    OP_DECODE, 16'h0001, 16'(ST_NONE)},
    '{ROW_SEEK,    OP_DECODE, 16'h0000, 16'(ST_SINGLE)},
    '{ROW_SEEK,    OP_DECODE, 16'h8000, 16'(ST_SINGLE)},
    '{ROW_SEEK,    OP_DECODE, 16'h0000, 16'(ST_DOUBLE)},
    '{ROW_SEEK,    OP_DECODE, 16'h0000, 16'(ST_FAIL)},
    '{ROW_SEEK,    OP_DECODE, 16'hFFFF, 16'(ST_FAIL)}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  decs_req_if req_if ();
  decs_rsp_if rsp_if ();

  double_error_syndrome_codec uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [CODE_BITS-1:0] check_rows [CHECK_BITS];
  res_t                 pending_results [$];
  res_t                 request_result;
  bit                   gaps_on = 1'b1;
  bit                   hold_rsp = 1'b0;
  int                   mismatches = 0;
  int                   idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic res_t predict_result(op_e op, logic [CODE_BITS-1:0] w);
    res_t                  r;
    logic [CHECK_BITS-1:0] cols [CODE_BITS];
    logic [CHECK_BITS-1:0] syn;
    logic                  found;
    r = '0;
    found = 1'b0;
    if (op == OP_ENCODE) begin
      r.word = w & DATA_MASK;
      for (int i = 0; i < CHECK_BITS; i++) begin
        r.word[CHECK_BITS-1-i] = ^(check_rows[i] & w & DATA_MASK);
      end
    end else begin
      for (int c = 0; c < CODE_BITS; c++) begin
        for (int i = 0; i < CHECK_BITS; i++) begin
          cols[c][CHECK_BITS-1-i] = check_rows[i][CODE_BITS-1-c];
        end
      end
      for (int i = 0; i < CHECK_BITS; i++) begin
        syn[CHECK_BITS-1-i] = ^(check_rows[i] & w);
      end
      r.word = w;
      r.syn = syn;
      if (syn != '0) begin
        for (int a = 0; a < CODE_BITS && !found; a++) begin
          if (cols[a] == syn) begin
            r.word = w ^ (TOP_BIT >> a);
            r.status = ST_SINGLE;
            r.pos_a = POS_W'(a + 1);
            found = 1'b1;
          end
        end
        for (int a = 0; a < CODE_BITS && !found; a++) begin
          for (int b = a + 1; b < CODE_BITS && !found; b++) begin
            if ((cols[a] ^ cols[b]) == syn) begin
              r.word = w ^ (TOP_BIT >> a) ^ (TOP_BIT >> b);
              r.status = ST_DOUBLE;
              r.pos_a = POS_W'(a + 1);
              r.pos_b = POS_W'(b + 1);
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          r.status = ST_FAIL;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(op_e op, logic [CODE_BITS-1:0] w, res_t want);
    while (gaps_on && $urandom_range(99) < 36) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.word_in <= w;
    request_result <= want;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, int idx, logic [APB_DATA_W-1:0] data,
                            output logic [APB_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(idx << 2);
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
  endtask

  task automatic verify_rows();
    logic [APB_DATA_W-1:0] rdata;
    for (int i = 0; i < CHECK_BITS; i++) begin
      apb_access(1'b0, i, '0, rdata);
      if (rdata !== APB_DATA_W'(check_rows[i])) begin
        report_mismatch($sformatf("check_row_%0d readback", i), rdata, check_rows[i]);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_check_rows(logic [CODE_BITS-1:0] vals [CHECK_BITS]);
    logic [APB_DATA_W-1:0] rdata;
    for (int i = 0; i < CHECK_BITS; i++) begin
      apb_access(1'b1, i, {16'($urandom), vals[i]}, rdata);
      check_rows[i] = vals[i];
    end
    verify_rows();
  endtask

  task automatic run_random(int count);
    op_e                  op;
    logic [CODE_BITS-1:0] w;
    res_t                 coded;
    int unsigned          pick;
    int unsigned          bitpos;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        op = OP_ENCODE;
        w = 16'($urandom);
      end else if (pick < 80) begin
        // A valid codeword with up to three bits flipped by the channel.
        op = OP_DECODE;
        coded = predict_result(OP_ENCODE, 16'($urandom));
        w = coded.word;
        repeat ($urandom_range(3)) begin
          bitpos = $urandom_range(CODE_BITS - 1);
          w[bitpos] = ~w[bitpos];
        end
      end else begin
        op = OP_DECODE;
        w = 16'($urandom);
      end
      send_request(op, w, predict_result(op, w));
    end
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_if.ready <= !gaps_on || ($urandom_range(99) >= 36);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t due;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("response with no request pending", rsp_if.word_out, 0);
        end else begin
          due = pending_results.pop_front();
          if (rsp_if.word_out !== due.word) begin
            report_mismatch("word_out", rsp_if.word_out, due.word);
          end
          if (rsp_if.syndrome !== due.syn) begin
            report_mismatch("syndrome", rsp_if.syndrome, due.syn);
          end
          if (rsp_if.status !== due.status) begin
            report_mismatch("status", rsp_if.status, due.status);
          end
          if (rsp_if.error_pos_a !== due.pos_a) begin
            report_mismatch("error_pos_a", rsp_if.error_pos_a, due.pos_a);
          end
          if (rsp_if.error_pos_b !== due.pos_b) begin
            report_mismatch("error_pos_b", rsp_if.error_pos_b, due.pos_b);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        pending_results = {pending_results, request_result};
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_double_error_syndrome_codec NOT OK");
        $finish;
      end
    end
  end

  initial begin
    codec_vector_t        vec;
    logic [CODE_BITS-1:0] w;
    logic [CODE_BITS-1:0] next_rows [CHECK_BITS];
    res_t                 want;
    res_t                 probe;
    int                   tries;

    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.op = OP_ENCODE;
    req_if.word_in = '0;
    request_result = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (check_rows[i]) check_rows[i] = DEFAULT_ROWS[i];

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    verify_rows();

    foreach (DIRECTED[i]) begin
      vec = DIRECTED[i];
      w = vec.word;
      if (vec.kind == ROW_SEEK) begin
        tries = 0;
        probe = predict_result(OP_DECODE, w);
        while (probe.status != status_e'(vec.aux[STATUS_W-1:0]) && tries < 65536) begin
          w++;
          tries++;
          probe = predict_result(OP_DECODE, w);
        end
      end
      if (vec.kind == ROW_CLEAN) begin
        want = '0;
        want.word = vec.aux;
      end else begin
        want = predict_result(vec.op, w);
      end
      send_request(vec.op, w, want);
    end

    run_random(300);

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      foreach (next_rows[i]) begin
        case (phase)
          0: begin
            next_rows[i] = '0;
          end
          1: begin
            next_rows[i] = '1;
          end
          4: begin
            next_rows[i] = DEFAULT_ROWS[i];
          end
          default: begin
            next_rows[i] = 16'($urandom);
          end
        endcase
      end
      load_check_rows(next_rows);
      gaps_on = (phase != 2);
      if (phase == 3) begin
        hold_rsp = 1'b1;
      end
      run_random(phase < 2 ? 150 : 300);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("results still pending", pending_results.size(), 0);
    end
    if (mismatches == 0) begin
      $display("tb_double_error_syndrome_codec OK");
    end else begin
      $display("tb_double_error_syndrome_codec NOT OK");
    end
    $finish;
  end

endmodule
